// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
package ple_pkg;

  localparam int unsigned PLE_REQ_W  = 3;
  localparam int unsigned PLE_DATA_W = 32;
  localparam int unsigned PLE_IDX_W  = 8;
  localparam int unsigned PLE_STS_W  = 2;

  // Request codes as carried in req_type
  typedef enum logic [PLE_REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_TRAVERSE  = 3'd6
  } ple_req_t;

  // Result status codes
  typedef enum logic [PLE_STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } ple_status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } ple_state_t;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } ple_cell_op_t;

  // Command broadcast along the chain
  typedef struct packed {
    ple_cell_op_t                op;
    logic [PLE_IDX_W-1:0]        idx;
    logic signed [PLE_DATA_W-1:0] value;
  } ple_cell_cmd_t;

endpackage

// ===== rtl/ple_if.sv =====
`timescale 1ns / 1ps
// Request channel
interface ple_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [ple_pkg::PLE_REQ_W-1:0]         req_type;
  logic signed [ple_pkg::PLE_DATA_W-1:0] item_value;
  logic [ple_pkg::PLE_IDX_W-1:0]         item_position;

  modport source(output valid, output req_type, output item_value, output item_position,
                 input ready);
  modport sink(input valid, input req_type, input item_value, input item_position,
               output ready);
endinterface

// Result channel
interface ple_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [ple_pkg::PLE_STS_W-1:0]         result_status;
  logic signed [ple_pkg::PLE_DATA_W-1:0] result_value;
  logic                                  result_last;

  modport source(output valid, output result_status, output result_value,
                 output result_last, input ready);
  modport sink(input valid, input result_status, input result_value,
               input result_last, output ready);
endinterface

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list; position IDX in the chain.
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                  clk,
  input  ple_pkg::ple_cell_cmd_t                cmd,
  input  logic signed [ple_pkg::PLE_DATA_W-1:0] left,
  input  logic signed [ple_pkg::PLE_DATA_W-1:0] right,
  input  logic signed [ple_pkg::PLE_DATA_W-1:0] head,
  output logic signed [ple_pkg::PLE_DATA_W-1:0] data
);

  localparam logic [ple_pkg::PLE_IDX_W-1:0] MyIdx = ple_pkg::PLE_IDX_W'(IDX);

  // insert: shift right past idx; delete: shift left from idx;
  // rotate: shift left below idx, wrap head into idx
  always_ff @(posedge clk) begin
    case (cmd.op)
      ple_pkg::CELL_INSERT: begin
        if (MyIdx == cmd.idx) begin
          data <= cmd.value;
        end else if (MyIdx > cmd.idx) begin
          data <= left;
        end
      end
      ple_pkg::CELL_DELETE: begin
        if (MyIdx >= cmd.idx) begin
          data <= right;
        end
      end
      ple_pkg::CELL_ROTATE: begin
        if (MyIdx == cmd.idx) begin
          data <= head;
        end else if (MyIdx < cmd.idx) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Edit and status requests: one per cycle while the result side is free, result next cycle.
// Traverse: after the traversal state is entered, one element per cycle is registered while
// the result side takes them; a new request is taken after the last element is registered.
// Edits shift the cells from the edit position on; traversal rotates the live cells by one.
// Reset (rst, synchronous) clears the count and the controller; cell contents are not reset.
module positional_list_engine_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = ple_pkg::PLE_IDX_W;
  localparam int unsigned DW = ple_pkg::PLE_DATA_W;

  ple_pkg::ple_state_t    state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          trav_cnt, trav_cnt_next;
  ple_pkg::ple_cell_cmd_t cmd;

  logic                   rsp_valid;
  ple_pkg::ple_status_t   rsp_status;
  logic signed [DW-1:0]   rsp_value;
  logic                   rsp_last;

  logic                   load;
  ple_pkg::ple_status_t   load_status;
  logic signed [DW-1:0]   load_value;
  logic                   load_last;

  logic                   out_free;
  logic                   accept;
  logic                   trav_done;
  logic [IW-1:0]          cnt_idx;
  logic                   is_full, is_empty;

  logic signed [DW-1:0]   cell_data [DEPTH];

  // Request decode
  logic                   dec_emit;
  logic                   dec_trav;
  ple_pkg::ple_status_t   dec_status;
  ple_pkg::ple_cell_op_t  dec_op;
  logic [IW-1:0]          dec_idx;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = !rst && (state == ple_pkg::ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign cnt_idx   = IW'(count);
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign trav_done = (trav_cnt == count - CW'(1));

  assign rsp.valid         = rsp_valid;
  assign rsp.result_status = rsp_status;
  assign rsp.result_value  = rsp_value;
  assign rsp.result_last   = rsp_last;

  always_comb begin
    dec_emit   = 1'b1;
    dec_trav   = 1'b0;
    dec_status = ple_pkg::STS_OK;
    dec_op     = ple_pkg::CELL_HOLD;
    dec_idx    = '0;
    case (ple_pkg::ple_req_t'(req.req_type))
      ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AT: begin
        if (req.req_type == ple_pkg::REQ_INS_END) begin
          dec_idx = cnt_idx;
        end else if (req.req_type == ple_pkg::REQ_INS_AT) begin
          dec_idx = req.item_position;
        end
        if (is_full) begin
          dec_status = ple_pkg::STS_FULL;
        end else if (dec_idx > cnt_idx) begin
          dec_status = ple_pkg::STS_RANGE;
        end else begin
          dec_op = ple_pkg::CELL_INSERT;
        end
      end
      ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AT: begin
        if (req.req_type == ple_pkg::REQ_DEL_END) begin
          dec_idx = cnt_idx - IW'(1);
        end else if (req.req_type == ple_pkg::REQ_DEL_AT) begin
          dec_idx = req.item_position;
        end
        if (is_empty) begin
          dec_status = ple_pkg::STS_EMPTY;
        end else if (dec_idx >= cnt_idx) begin
          dec_status = ple_pkg::STS_RANGE;
        end else begin
          dec_op = ple_pkg::CELL_DELETE;
        end
      end
      ple_pkg::REQ_TRAVERSE: begin
        if (is_empty) begin
          dec_status = ple_pkg::STS_EMPTY;
        end else begin
          dec_emit = 1'b0;
          dec_trav = 1'b1;
        end
      end
      default: begin
        dec_emit = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::ST_IDLE: begin
        if (accept && dec_trav) begin
          state_next = ple_pkg::ST_TRAV;
        end
      end
      ple_pkg::ST_TRAV: begin
        if (out_free && trav_done) begin
          state_next = ple_pkg::ST_IDLE;
        end
      end
      default: state_next = ple_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: cell command, result load, count update
  always_comb begin
    cmd           = '{op: ple_pkg::CELL_HOLD, idx: '0, value: '0};
    load          = 1'b0;
    load_status   = ple_pkg::STS_OK;
    load_value    = '0;
    load_last     = 1'b1;
    count_next    = count;
    trav_cnt_next = trav_cnt;
    case (state)
      ple_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.op      = dec_op;
          cmd.idx     = dec_idx;
          cmd.value   = req.item_value;
          load        = dec_emit;
          load_status = dec_status;
          if (dec_op == ple_pkg::CELL_INSERT) begin
            count_next = count + CW'(1);
          end else if (dec_op == ple_pkg::CELL_DELETE) begin
            count_next = count - CW'(1);
          end
        end
        trav_cnt_next = '0;
      end
      ple_pkg::ST_TRAV: begin
        if (out_free) begin
          cmd.op        = ple_pkg::CELL_ROTATE;
          cmd.idx       = cnt_idx - IW'(1);
          load          = 1'b1;
          load_value    = cell_data[0];
          load_last     = trav_done;
          trav_cnt_next = trav_cnt + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ple_pkg::ST_IDLE;
      count     <= '0;
      trav_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      trav_cnt <= trav_cnt_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status <= load_status;
      rsp_value  <= load_value;
      rsp_last   <= load_last;
    end
  end

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DW-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ple_cell #(
      .IDX(g)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .left (left_d),
      .right(right_d),
      .head (cell_data[0]),
      .data (cell_data[g])
    );
  end

endmodule

// ===== rtl/ple_checker.sv =====
`timescale 1ns / 1ps
module ple_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  req_valid,
  input logic                                  req_ready,
  input logic                                  rsp_valid,
  input logic                                  rsp_ready,
  input logic [ple_pkg::PLE_STS_W-1:0]         rsp_status,
  input logic signed [ple_pkg::PLE_DATA_W-1:0] rsp_value,
  input logic                                  rsp_last
);

  // A stalled result stays offered
  a_rsp_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload
  a_rsp_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_last))
    else $error("result payload changed while stalled");

  // Any non-ok status is a single, final result with zero value
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ple_pkg::STS_OK) |-> rsp_last && (rsp_value == '0))
    else $error("error status not a lone zero result");

  // No new request is taken in the middle of a traversal
  a_no_accept_mid_trav: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !(req_valid && req_ready))
    else $error("request accepted during traversal");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_status(rsp.result_status),
  .rsp_value (rsp.result_value),
  .rsp_last  (rsp.result_last)
);

// ===== tb/ple_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels, keeps its own copy of the ordered list, and checks every
// result transaction against the oldest result still awaited.
module ple_scoreboard (
  input  logic        clk,
  input  logic        rst,
  ple_req_if          req,
  ple_rsp_if          rsp,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned fail_count
);

  localparam int LIST_CAP = 16;

  typedef struct {
    ple_pkg::ple_status_t                  status;
    logic signed [ple_pkg::PLE_DATA_W-1:0] value;
    logic                                  last;
  } list_result_t;

  // Current list contents, front first
  logic signed [ple_pkg::PLE_DATA_W-1:0] shadow_list[$];
  // Results owed by the block, oldest first
  list_result_t                          awaited_q[$];

  function automatic void post_status(ple_pkg::ple_status_t s);
    list_result_t r;
    r.status = s;
    r.value  = '0;
    r.last   = 1'b1;
    awaited_q.push_back(r);
  endfunction

  // Full is checked before range
  function automatic ple_pkg::ple_status_t list_insert(
      int idx, logic signed [ple_pkg::PLE_DATA_W-1:0] v);
    if (shadow_list.size() >= LIST_CAP) return ple_pkg::STS_FULL;
    if (idx > shadow_list.size()) return ple_pkg::STS_RANGE;
    shadow_list.insert(idx, v);
    return ple_pkg::STS_OK;
  endfunction

  // Empty is checked before range
  function automatic ple_pkg::ple_status_t list_remove(int idx);
    if (shadow_list.size() == 0) return ple_pkg::STS_EMPTY;
    if (idx >= shadow_list.size()) return ple_pkg::STS_RANGE;
    shadow_list.delete(idx);
    return ple_pkg::STS_OK;
  endfunction

  function automatic void predict_request(logic [ple_pkg::PLE_REQ_W-1:0] kind,
                                          logic signed [ple_pkg::PLE_DATA_W-1:0] v,
                                          logic [ple_pkg::PLE_IDX_W-1:0] pos);
    list_result_t r;
    int tail;
    tail = (shadow_list.size() == 0) ? 0 : shadow_list.size() - 1;
    case (kind)
      ple_pkg::REQ_INS_FRONT: post_status(list_insert(0, v));
      ple_pkg::REQ_INS_END:   post_status(list_insert(shadow_list.size(), v));
      ple_pkg::REQ_INS_AT:    post_status(list_insert(int'(pos), v));
      ple_pkg::REQ_DEL_FRONT: post_status(list_remove(0));
      ple_pkg::REQ_DEL_END:   post_status(list_remove(tail));
      ple_pkg::REQ_DEL_AT:    post_status(list_remove(int'(pos)));
      ple_pkg::REQ_TRAVERSE: begin
        if (shadow_list.size() == 0) begin
          post_status(ple_pkg::STS_EMPTY);
        end else begin
          foreach (shadow_list[i]) begin
            r.status = ple_pkg::STS_OK;
            r.value  = shadow_list[i];
            r.last   = (i == shadow_list.size() - 1);
            awaited_q.push_back(r);
          end
        end
      end
      // unused code: no effect, no result
      default: ;
    endcase
  endfunction

  // Compare results first; a request accepted on this edge cannot answer yet
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_list.delete();
      awaited_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (awaited_q.size() == 0) begin
          $error("unexpected result: status %0d value %0d last %0d",
                 rsp.result_status, rsp.result_value, rsp.result_last);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (rsp.result_status !== want.status) begin
            $error("result_status: expected %0d, got %0d", want.status, rsp.result_status);
            fail_count++;
          end
          if (rsp.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, rsp.result_value);
            fail_count++;
          end
          if (rsp.result_last !== want.last) begin
            $error("result_last: expected %0d, got %0d", want.last, rsp.result_last);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_request(req.req_type, req.item_value, req.item_position);
      end
    end
    pending = awaited_q.size();
  end

endmodule

// ===== tb/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
module tb_positional_list_engine_unit;

  localparam logic [ple_pkg::PLE_REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int unsigned LIST_CAP     = 16;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned CYCLE_LIMIT  = 300_000;

  logic        clk = 1'b0;
  logic        rst;
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned pending, results_seen, fail_count;
  int unsigned n_ins = 0, n_del = 0, n_trav = 0, n_unused = 0;

  ple_req_if req ();
  ple_rsp_if rsp ();

  positional_list_engine_unit #(.DEPTH(LIST_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  ple_scoreboard u_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .pending(pending),
    .results_seen(results_seen),
    .fail_count(fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side stalls at random except in the calm stretch
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One request transaction, with random idle cycles before it
  task automatic push_req(input logic [ple_pkg::PLE_REQ_W-1:0] kind,
                          input logic signed [ple_pkg::PLE_DATA_W-1:0] value,
                          input logic [ple_pkg::PLE_IDX_W-1:0] pos);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.req_type      <= kind;
    req.item_value    <= value;
    req.item_position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (kind)
      ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AT: n_ins++;
      ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AT: n_del++;
      ple_pkg::REQ_TRAVERSE: n_trav++;
      default: n_unused++;
    endcase
  endtask

  // Hold off until every owed result has come back
  task automatic drain_results();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [ple_pkg::PLE_DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions near the live range, sometimes anywhere
  function automatic logic [ple_pkg::PLE_IDX_W-1:0] pick_position();
    if ($urandom_range(99) < 85) return ple_pkg::PLE_IDX_W'($urandom_range(LIST_CAP + 1));
    return ple_pkg::PLE_IDX_W'($urandom_range(255));
  endfunction

  // Growing phases favor inserts, shrinking phases favor deletes
  function automatic logic [ple_pkg::PLE_REQ_W-1:0] pick_kind(bit growing);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return REQ_UNUSED;
    if (roll < 12) return ple_pkg::REQ_TRAVERSE;
    if (roll < (growing ? 72 : 37)) begin
      case ($urandom_range(2))
        0: return ple_pkg::REQ_INS_FRONT;
        1: return ple_pkg::REQ_INS_END;
        default: return ple_pkg::REQ_INS_AT;
      endcase
    end
    case ($urandom_range(2))
      0: return ple_pkg::REQ_DEL_FRONT;
      1: return ple_pkg::REQ_DEL_END;
      default: return ple_pkg::REQ_DEL_AT;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    logic [ple_pkg::PLE_REQ_W-1:0] kind;
    req.valid         <= 1'b0;
    req.req_type      <= ple_pkg::REQ_TRAVERSE;
    req.item_value    <= '0;
    req.item_position <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty list: traverse and every delete report empty, insert at 1 is out of range
    push_req(ple_pkg::REQ_TRAVERSE, '0, '0);
    push_req(ple_pkg::REQ_DEL_FRONT, '0, '0);
    push_req(ple_pkg::REQ_DEL_END, '0, '0);
    push_req(ple_pkg::REQ_DEL_AT, '0, 8'd0);
    push_req(ple_pkg::REQ_INS_AT, 32'sd7, 8'd1);
    // Build a short list with extreme values; insert at count appends
    push_req(ple_pkg::REQ_INS_AT, 32'sh8000_0000, 8'd0);
    push_req(ple_pkg::REQ_INS_FRONT, 32'sh7fff_ffff, '0);
    push_req(ple_pkg::REQ_INS_END, -32'sd1, '0);
    push_req(ple_pkg::REQ_INS_AT, '0, 8'd3);
    push_req(ple_pkg::REQ_INS_AT, 32'sh5555_5555, 8'd1);
    push_req(ple_pkg::REQ_TRAVERSE, '0, '0);
    // Out of range positions, and the unused code
    push_req(ple_pkg::REQ_DEL_AT, '0, 8'd5);
    push_req(ple_pkg::REQ_DEL_AT, '0, 8'd255);
    push_req(ple_pkg::REQ_INS_AT, 32'sh2aaa_aaaa, 8'd255);
    push_req(REQ_UNUSED, 32'sh1234_5678, 8'd1);
    // Delete down to nothing, the last one removing the only element
    push_req(ple_pkg::REQ_DEL_AT, '0, 8'd2);
    push_req(ple_pkg::REQ_DEL_END, '0, '0);
    push_req(ple_pkg::REQ_DEL_AT, '0, 8'd1);
    push_req(ple_pkg::REQ_DEL_FRONT, '0, '0);
    push_req(ple_pkg::REQ_DEL_FRONT, '0, '0);
    push_req(ple_pkg::REQ_TRAVERSE, '0, '0);
    // Fill to capacity; further inserts report full, even with a bad position
    for (int k = 0; k < LIST_CAP; k++) push_req(ple_pkg::REQ_INS_END, pick_value(), '0);
    push_req(ple_pkg::REQ_INS_FRONT, 32'sd1, '0);
    push_req(ple_pkg::REQ_INS_AT, 32'sd2, 8'd255);
    push_req(ple_pkg::REQ_INS_END, 32'sd3, '0);
    push_req(ple_pkg::REQ_TRAVERSE, '0, '0);
    drain_results();

    // Random traffic in alternating grow and shrink phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 100 && sent < 200);
      kind = pick_kind((sent / 40) % 2 == 0);
      if (kind != REQ_UNUSED) begin
        if (sent == 240) drain_results();
        sent++;
      end
      push_req(kind, pick_value(), pick_position());
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);

    $display("tb: %0d requests (%0d inserts, %0d deletes, %0d traversals, %0d unused codes)",
             n_ins + n_del + n_trav + n_unused, n_ins, n_del, n_trav, n_unused);
    $display("tb: %0d results compared, %0d mismatches, %0d still owed",
             results_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
tb/ple_checker.sv
tb/tb_positional_list_engine_unit.sv
